### src/ddm_pkg.sv
// ----------------------------------------------------------------------------
// ddm_pkg
// Shared codes, field widths and controller/datapath interface types for the
// middle-delete deque.
// ----------------------------------------------------------------------------
package ddm_pkg;

  localparam int DDM_DEPTH      = 16;
  localparam int DDM_DATA_WIDTH = 32;

  localparam int ACTION_W = 2;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DEL_MID    = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_READ       = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic latch;
    logic decode;
    logic push_front;
    logic push_back;
    logic rd_item;
    logic shift_init;
    logic capture;
    logic rd_shift;
    logic shift_wr;
    logic remove_fin;
    logic load_out;
  } ddm_cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                ok;
    logic                shift_done;
  } ddm_stat_t;

endpackage

### src/ddm_dp.sv
// ----------------------------------------------------------------------------
// ddm_dp
// Datapath: circular element store, front pointer, element count, request
// latch, shift index and result/output registers.
// ----------------------------------------------------------------------------
module ddm_dp #(
  parameter int DEPTH      = ddm_pkg::DDM_DEPTH,
  parameter int DATA_WIDTH = ddm_pkg::DDM_DATA_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ddm_pkg::ddm_cmd_t                   cmd,
  output ddm_pkg::ddm_stat_t                  stat,
  input  logic        [ddm_pkg::ACTION_W-1:0] in_action,
  input  logic signed [ddm_pkg::VALUE_W-1:0]  in_value,
  input  logic        [ddm_pkg::POS_W-1:0]    in_position,
  output logic        [ddm_pkg::STATUS_W-1:0] out_status,
  output logic signed [ddm_pkg::VALUE_W-1:0]  out_data,
  output logic        [ddm_pkg::OCC_W-1:0]    out_occupancy
);
  import ddm_pkg::*;

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int SW   = CW + 1;
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  logic [DATA_WIDTH-1:0]     mem_r [DEPTH];
  logic [DATA_WIDTH-1:0]     rdata_r;

  logic [ACTION_W-1:0]       act_r;
  logic signed [VALUE_W-1:0] val_r;
  logic [POS_W-1:0]          pos_r;
  logic [AW-1:0]             front_r, front_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [CW-1:0]             idx_r;
  logic                      side_r;
  logic [STATUS_W-1:0]       res_status_r;
  logic [VALUE_W-1:0]        res_data_r;
  logic [STATUS_W-1:0]       out_status_r;
  logic [VALUE_W-1:0]        out_data_r;
  logic [OCC_W-1:0]          out_occ_r;

  logic [CW-1:0]             mid, after, idx_prev, idx_next, rd_logical;
  logic                      empty, full, pos_hit;
  logic [STATUS_W-1:0]       code;
  logic [AW-1:0]             front_dec, front_inc, rd_addr, wr_addr;
  logic                      rd_en, wr_en;
  logic [DATA_WIDTH-1:0]     wr_data;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] f,
                                            input logic [CW-1:0] l);
    logic [SW-1:0] s;
    s = SW'(f) + SW'(l);
    if (s >= SW'(DEPTH)) s = s - SW'(DEPTH);
    return AW'(s);
  endfunction

  assign mid      = count_r >> 1;
  assign after    = count_r - CW'(1) - mid;
  assign empty    = (count_r == '0);
  assign full     = (count_r == CW'(DEPTH));
  assign pos_hit  = (CMPW'(pos_r) < CMPW'(count_r));
  assign idx_prev = idx_r - CW'(1);
  assign idx_next = idx_r + CW'(1);

  always_comb begin
    case (act_r)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: code = full ? ST_FULL : ST_OK;
      ACT_DEL_MID:                   code = empty ? ST_EMPTY : ST_OK;
      default: begin
        if (empty)         code = ST_EMPTY;
        else if (!pos_hit) code = ST_RANGE;
        else               code = ST_OK;
      end
    endcase
  end

  assign stat.action     = act_r;
  assign stat.ok         = (code == ST_OK);
  assign stat.shift_done = side_r ? (idx_r == '0) : (idx_next >= count_r);

  assign front_dec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - AW'(1);
  assign front_inc = (front_r == AW'(DEPTH - 1)) ? '0 : front_r + AW'(1);

  assign rd_logical = cmd.rd_item ? ((act_r == ACT_READ) ? CW'(pos_r) : mid)
                                  : (side_r ? idx_prev : idx_next);
  assign rd_addr = slot_of(front_r, rd_logical);
  assign rd_en   = cmd.rd_item | cmd.rd_shift;

  assign wr_en   = cmd.push_front | cmd.push_back | cmd.shift_wr;
  assign wr_addr = cmd.push_front ? front_dec :
                   cmd.push_back  ? slot_of(front_r, count_r) : slot_of(front_r, idx_r);
  assign wr_data = (cmd.push_front | cmd.push_back) ? DATA_WIDTH'(val_r) : rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= mem_r[rd_addr];
  end

  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    if (cmd.push_front) begin
      front_nxt = front_dec;
      count_nxt = count_r + CW'(1);
    end else if (cmd.push_back) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.remove_fin) begin
      if (side_r) front_nxt = front_inc;
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r <= in_action;
      val_r <= in_value;
      pos_r <= in_position;
    end
    if (cmd.decode) begin
      res_status_r <= code;
      res_data_r   <= '0;
    end
    if (cmd.capture) res_data_r <= VALUE_W'(rdata_r);
    if (cmd.shift_init) begin
      idx_r  <= mid;
      side_r <= (mid < after);
    end
    if (cmd.shift_wr) idx_r <= side_r ? idx_prev : idx_next;
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_data_r   <= res_data_r;
      out_occ_r    <= OCC_W'(count_r);
    end
  end

  assign out_status    = out_status_r;
  assign out_data      = out_data_r;
  assign out_occupancy = out_occ_r;

endmodule

### src/ddm_ctrl.sv
// ----------------------------------------------------------------------------
// ddm_ctrl
// Controller: sequences decode, store reads, middle-removal shifting and the
// result handoff.
// ----------------------------------------------------------------------------
module ddm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  ddm_pkg::ddm_stat_t stat,
  output ddm_pkg::ddm_cmd_t  cmd
);
  import ddm_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_RDWAIT = 3'd2;
  localparam logic [2:0] S_SHRD   = 3'd3;
  localparam logic [2:0] S_SHWR   = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & out_stall;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = S_DONE;
        if (stat.ok) begin
          case (stat.action)
            ACT_PUSH_FRONT: cmd.push_front = 1'b1;
            ACT_PUSH_BACK:  cmd.push_back  = 1'b1;
            ACT_DEL_MID: begin
              cmd.rd_item    = 1'b1;
              cmd.shift_init = 1'b1;
              state_nxt      = S_RDWAIT;
            end
            default: begin
              cmd.rd_item = 1'b1;
              state_nxt   = S_RDWAIT;
            end
          endcase
        end
      end
      S_RDWAIT: begin
        cmd.capture = 1'b1;
        state_nxt   = (stat.action == ACT_DEL_MID) ? S_SHRD : S_DONE;
      end
      S_SHRD: begin
        if (stat.shift_done) begin
          cmd.remove_fin = 1'b1;
          state_nxt      = S_DONE;
        end else begin
          cmd.rd_shift = 1'b1;
          state_nxt    = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd.shift_wr = 1'b1;
        state_nxt    = S_SHRD;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### src/deque_delete_middle_top.sv
// ----------------------------------------------------------------------------
// deque_delete_middle_top
// Bounded deque of signed words with push front/back, middle delete and
// indexed read, one result per request.
// ----------------------------------------------------------------------------
// pushes and refused requests pass decode and done; reads add a store-read wait;
// a middle delete then shifts k elements (k at most DEPTH/2), with
// one store read and one store write per shifted element
// requests are handled one at a time; the next is taken while a result waits
// reset: synchronous active-low rst_n empties the deque and clears out_valid
// ----------------------------------------------------------------------------
module deque_delete_middle_top #(
  parameter int DEPTH      = ddm_pkg::DDM_DEPTH,
  parameter int DATA_WIDTH = ddm_pkg::DDM_DATA_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic        [ddm_pkg::ACTION_W-1:0] in_action,
  input  logic signed [ddm_pkg::VALUE_W-1:0]  in_value,
  input  logic        [ddm_pkg::POS_W-1:0]    in_position,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic        [ddm_pkg::STATUS_W-1:0] out_status,
  output logic signed [ddm_pkg::VALUE_W-1:0]  out_data,
  output logic        [ddm_pkg::OCC_W-1:0]    out_occupancy
);
  import ddm_pkg::*;

  ddm_cmd_t  cmd;
  ddm_stat_t stat;

  ddm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ddm_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_action     (in_action),
    .in_value      (in_value),
    .in_position   (in_position),
    .out_status    (out_status),
    .out_data      (out_data),
    .out_occupancy (out_occupancy)
  );

endmodule

### src/ddm_checker.sv
// ----------------------------------------------------------------------------
// ddm_checker
// Port-level checks on results of the middle-delete deque, bound to the top.
// ----------------------------------------------------------------------------
module ddm_checker #(
  parameter int DEPTH = ddm_pkg::DDM_DEPTH
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic        [ddm_pkg::STATUS_W-1:0] out_status,
  input logic signed [ddm_pkg::VALUE_W-1:0]  out_data,
  input logic        [ddm_pkg::OCC_W-1:0]    out_occupancy
);
  import ddm_pkg::*;

  a_refused_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_data == '0)
    else $error("refused request carries data");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_occupancy == '0)
    else $error("empty status with nonzero occupancy");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_occupancy == OCC_W'(DEPTH))
    else $error("full status without full occupancy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data) && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind deque_delete_middle_top ddm_checker #(.DEPTH(DEPTH)) u_ddm_checker (.*);
